@@ rtl/multi_queue_fifo_top_defines.svh @@
// Assertion macros shared by the multi-queue FIFO RTL.
// Include by bare file name; no other dependencies.
`ifndef MULTI_QUEUE_FIFO_TOP_DEFINES_SVH
`define MULTI_QUEUE_FIFO_TOP_DEFINES_SVH

`ifndef SYNTH
`define MQF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mqf assertion failed");
`define MQF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mqf assertion failed");
`else
`define MQF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MQF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/mqf_pkg.sv @@
// Package for the multi-queue FIFO: field widths, command and status codes,
// and the classified command type passed from front end to back end.
`timescale 1ns / 1ps

package mqf_pkg;

  localparam int CMD_W       = 2;
  localparam int IDX_W       = 3;
  localparam int DATA_W      = 32;
  localparam int LOST_W      = 32;
  localparam int OCC_W       = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 72;

  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_INIT,
    OP_WRITE,
    OP_READ,
    OP_NOP,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  qidx;
    logic [DATA_W-1:0] wdata;
  } item_t;

endpackage

@@ rtl/multi_queue_fifo_top.sv @@
// A command passes the front-end queue and the back-end result register before
// its result beat. Throughput: one command per cycle unless out_tready stalls,
// set by the single word-store port and the per-queue state update.
// Reset (rst_n low, synchronous) clears all head/tail pointers, fill counts and
// lost counters; the word store is not cleared, so no clearing pass is needed.
// Top level of the multi-queue FIFO; instantiates mqf_front and mqf_back.
`timescale 1ns / 1ps

module multi_queue_fifo_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int QUEUE_COUNT = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [2:0] queue_index, [34:3] write_data, [39:35] zero
  input  logic [mqf_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] command
  input  logic [mqf_pkg::CMD_W-1:0]       in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] read_data, [63:32] lost_count, [68:64] occupancy, [71:69] zero
  output logic [mqf_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [1:0] status
  output logic [1:0]                      out_tuser
);

  logic           q_valid, q_ready;
  mqf_pkg::item_t q_item;

  mqf_front #(
    .QUEUE_COUNT (QUEUE_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  mqf_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .QUEUE_COUNT (QUEUE_COUNT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ rtl/mqf_front.sv @@
// Front end: accepts input beats, decodes the command and range-checks the
// queue index, and holds classified commands in a two-entry queue. Uses mqf_pkg.
`timescale 1ns / 1ps
`include "multi_queue_fifo_top_defines.svh"

module mqf_front #(
  parameter int QUEUE_COUNT = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [mqf_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [mqf_pkg::CMD_W-1:0]      in_tuser,
  output logic                          q_valid,
  input  logic                          q_ready,
  output mqf_pkg::item_t                q_item
);

  mqf_pkg::item_t entry_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     cnt_r, cnt_nxt;
  mqf_pkg::item_t cls;
  logic           push, pop;

  always_comb begin
    cls.qidx  = in_tdata[mqf_pkg::IDX_W-1:0];
    cls.wdata = in_tdata[mqf_pkg::IDX_W +: mqf_pkg::DATA_W];
    if ({1'b0, cls.qidx} >= (mqf_pkg::IDX_W+1)'(QUEUE_COUNT)) begin
      cls.op = mqf_pkg::OP_BAD;
    end else begin
      unique case (in_tuser)
        mqf_pkg::CMD_INIT:  cls.op = mqf_pkg::OP_INIT;
        mqf_pkg::CMD_WRITE: cls.op = mqf_pkg::OP_WRITE;
        mqf_pkg::CMD_READ:  cls.op = mqf_pkg::OP_READ;
        default:            cls.op = mqf_pkg::OP_NOP;
      endcase
    end
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_item    = entry_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= cls;
  end

  `MQF_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= 2'd2)
  `MQF_ASSERT_IMP(a_pop_nonempty, clk, rst_n, pop, cnt_r != 2'd0)
  `MQF_ASSERT_NXT(a_push_only, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + 2'd1)

endmodule

@@ rtl/mqf_back.sv @@
// Back end: per-queue head/tail/fill/lost state, the shared word store and the
// result register. Executes one classified command per beat. Uses mqf_pkg.
`timescale 1ns / 1ps
`include "multi_queue_fifo_top_defines.svh"

module mqf_back #(
  parameter int QUEUE_DEPTH = 16,
  parameter int QUEUE_COUNT = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  output logic                            q_ready,
  input  mqf_pkg::item_t                  q_item,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mqf_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]                      out_tuser
);

  localparam int QW    = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int TOTAL = QUEUE_COUNT * QUEUE_DEPTH;
  localparam int AW    = $clog2(TOTAL);

  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

  logic [PW-1:0]             head_r [QUEUE_COUNT];
  logic [PW-1:0]             tail_r [QUEUE_COUNT];
  logic [CW-1:0]             fill_r [QUEUE_COUNT];
  logic [mqf_pkg::LOST_W-1:0] lost_r [QUEUE_COUNT];

  logic [mqf_pkg::DATA_W-1:0] mem [TOTAL];
  logic [mqf_pkg::DATA_W-1:0] mem_q_r;

  logic                       out_valid_r;
  mqf_pkg::status_t           status_r, status_nxt;
  logic                       rd_ok_r, rd_ok_nxt;
  logic [mqf_pkg::LOST_W-1:0] lost_out_r, lost_out_nxt;
  logic [CW-1:0]              occ_r, occ_nxt;

  logic [QW-1:0]              qi;
  logic [PW-1:0]              head_cur, tail_cur, head_nxt, tail_nxt;
  logic [CW-1:0]              fill_cur, fill_nxt;
  logic [mqf_pkg::LOST_W-1:0] lost_cur, lost_nxt;
  logic                       pop, upd, mem_we, mem_re;
  logic [AW-1:0]              addr;

  assign pop     = q_valid && (!out_valid_r || out_tready);
  assign q_ready = !out_valid_r || out_tready;
  assign qi      = q_item.qidx[QW-1:0];

  assign head_cur = head_r[qi];
  assign tail_cur = tail_r[qi];
  assign fill_cur = fill_r[qi];
  assign lost_cur = lost_r[qi];

  always_comb begin
    head_nxt     = head_cur;
    tail_nxt     = tail_cur;
    fill_nxt     = fill_cur;
    lost_nxt     = lost_cur;
    status_nxt   = mqf_pkg::ST_OK;
    rd_ok_nxt    = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    upd          = 1'b0;
    addr         = AW'(QUEUE_DEPTH) * AW'(qi) + AW'(head_cur);
    unique case (q_item.op)
      mqf_pkg::OP_INIT: begin
        head_nxt = '0;
        tail_nxt = '0;
        fill_nxt = '0;
        lost_nxt = '0;
        upd      = 1'b1;
      end
      mqf_pkg::OP_WRITE: begin
        upd  = 1'b1;
        addr = AW'(QUEUE_DEPTH) * AW'(qi) + AW'(tail_cur);
        if (fill_cur == CNT_FULL) begin
          status_nxt = mqf_pkg::ST_FULL;
          if (lost_cur != '1) lost_nxt = lost_cur + 1'b1;
        end else begin
          mem_we   = 1'b1;
          tail_nxt = (tail_cur == PTR_LAST) ? '0 : tail_cur + 1'b1;
          fill_nxt = fill_cur + 1'b1;
        end
      end
      mqf_pkg::OP_READ: begin
        upd = 1'b1;
        if (fill_cur == '0) begin
          status_nxt = mqf_pkg::ST_EMPTY;
        end else begin
          mem_re    = 1'b1;
          rd_ok_nxt = 1'b1;
          head_nxt  = (head_cur == PTR_LAST) ? '0 : head_cur + 1'b1;
          fill_nxt  = fill_cur - 1'b1;
        end
      end
      mqf_pkg::OP_NOP: begin
        upd = 1'b0;
      end
      default: begin
        status_nxt = mqf_pkg::ST_BAD_INDEX;
      end
    endcase
    // bad index reports zero counts; index may be past the state arrays
    if (q_item.op == mqf_pkg::OP_BAD) begin
      lost_out_nxt = '0;
      occ_nxt      = '0;
    end else begin
      lost_out_nxt = lost_nxt;
      occ_nxt      = fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        fill_r[i] <= '0;
        lost_r[i] <= '0;
      end
    end else if (pop && upd) begin
      head_r[qi] <= head_nxt;
      tail_r[qi] <= tail_nxt;
      fill_r[qi] <= fill_nxt;
      lost_r[qi] <= lost_nxt;
    end
  end

  // word store, one access per beat; read data registered
  always_ff @(posedge clk) begin
    if (pop && mem_we) mem[addr] <= q_item.wdata;
    if (pop && mem_re) mem_q_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status_r   <= status_nxt;
      rd_ok_r    <= rd_ok_nxt;
      lost_out_r <= lost_out_nxt;
      occ_r      <= occ_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {3'b000, mqf_pkg::OCC_W'(occ_r), lost_out_r,
                       rd_ok_r ? mem_q_r : {mqf_pkg::DATA_W{1'b0}}};

  `MQF_ASSERT_IMP(a_stall_no_pop, clk, rst_n, out_valid_r && !out_tready, !pop)
  `MQF_ASSERT_NXT(a_bad_status, clk, rst_n, pop && q_item.op == mqf_pkg::OP_BAD,
                  status_r == mqf_pkg::ST_BAD_INDEX && occ_r == '0)
  `MQF_ASSERT_IMP(a_fill_bound, clk, rst_n, pop && q_item.op != mqf_pkg::OP_BAD,
                  fill_cur <= CNT_FULL)
  `MQF_ASSERT_IMP(a_full_occ, clk, rst_n, out_valid_r && status_r == mqf_pkg::ST_FULL,
                  occ_r == CNT_FULL)

endmodule
